// ===== src/asc_pkg.sv =====
// Shared types and constants for the alarm snooze controller.
// Holds the request and response beat structs, the mode enum and the event codes.
// No dependencies.
package asc_pkg;

	localparam int SLOT_W = 12;
	localparam int SLOT_REGS_MAX = 4;
	localparam int SEC_W = 14;
	localparam logic [9:0] LED_FULL = 10'h3FF;
	localparam logic [1:0] PRE_TICKS = 2'd3;

	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_INIT    = 3'd1,
		MODE_ON      = 3'd2,
		MODE_SNOOZE  = 3'd3,
		MODE_DISABLE = 3'd4,
		MODE_WAIT    = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		FUNC_POLL      = 2'd0,
		FUNC_TICK      = 2'd1,
		FUNC_INIT_DONE = 2'd2,
		FUNC_DISABLE   = 2'd3
	} func_t;

	localparam logic [2:0] CFG_RING_MINUTES   = 3'd4;
	localparam logic [2:0] CFG_SNOOZE_MINUTES = 3'd5;
	localparam logic [2:0] CFG_RING_ATTEMPTS  = 3'd6;

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [7:0] wanted_sound;
		logic [7:0] random_value;
		logic       player_busy;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] led_level;
		logic       start_sound;
		logic [7:0] sound_number;
		logic       announce_time;
		logic       stop_sound;
		logic       wake_display;
		logic       can_disable;
	} rsp_t;

	typedef struct packed {
		logic any_enabled;
		logic any_match;
	} match_t;

endpackage

// ===== src/asc_match.sv =====
// Alarm slot comparator: checks all slots against the current time.
// Depends on asc_pkg for the slot width and the match status struct.
module asc_match #(
	parameter int N = 4
) (
	input  logic [N-1:0][asc_pkg::SLOT_W-1:0] slots,
	input  logic [4:0]                        hour,
	input  logic [5:0]                        minute,
	input  logic [5:0]                        second,
	output asc_pkg::match_t                   result
);
	import asc_pkg::*;

	always_comb begin
		result = '0;
		for (int i = 0; i < N; i++) begin
			if (slots[i][11]) begin
				result.any_enabled = 1'b1;
				if (second == 6'd0 && slots[i][10:6] == hour && slots[i][5:0] == minute) begin
					result.any_match = 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/alarm_snooze_controller.sv =====
// Top level of the alarm snooze controller: event register, mode sequencer, result register.
// Depends on asc_pkg and asc_match.
//
// Usage:
// Events enter on the req channel (valid/ready) as one req_t beat each: a poll with the
// current time, a one-second tick, an init-finished notice or a disable request.
// Every event yields exactly one rsp_t beat on the rsp channel with the mode, the LED
// level, the selected sound and the request flags for the player, speech and display.
// The cfg channel writes the alarm slots and the ring, snooze and attempt settings;
// it is always ready and should only be used while no event is in flight.
// A beat accepted on req is held in the event register, and its result is captured in the
// result register, which drives rsp. The event register feeds one pass of sequencer logic
// into the result register, so one beat per cycle is sustained while the receiver keeps
// rsp_ready high. When the receiver stalls, the result register holds its beat and the
// event register takes one more beat; req_ready drops once both are full.
// Reset puts the sequencer in the off mode with all counters and the LED level at zero,
// clears every slot and loads ring and snooze lengths of five minutes and three attempts.
module alarm_snooze_controller #(
	parameter int SLOTS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  asc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output asc_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [11:0]   cfg_data
);
	import asc_pkg::*;

	localparam int NREG = (SLOTS < SLOT_REGS_MAX) ? SLOTS : SLOT_REGS_MAX;

	logic [NREG-1:0][SLOT_W-1:0] slot_q;
	logic [7:0] ring_min_q, snooze_min_q, attempts_cfg_q;

	logic valid_s1;
	req_t req_s1;
	logic adv_s1;

	mode_t mode_q, mode_n, mode_p;
	logic [1:0] delay_q, delay_n;
	logic [SEC_W-1:0] ring_q, ring_n, snooze_q, snooze_n;
	logic [SEC_W-1:0] ring_load, snooze_load;
	logic [7:0] attempts_q, attempts_n, att_dec;
	logic [9:0] bright_q, bright_n;
	logic [7:0] sound_q, sound_n;
	logic start_n, announce_n, stop_n, wake_n, hold_led;
	logic delay_p;

	match_t match;
	rsp_t rsp_q;
	logic rsp_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q         <= '0;
			ring_min_q     <= 8'd5;
			snooze_min_q   <= 8'd5;
			attempts_cfg_q <= 8'd3;
		end else if (cfg_valid) begin
			for (int i = 0; i < NREG; i++) begin
				if (cfg_index == 3'(i)) begin
					slot_q[i] <= cfg_data;
				end
			end
			if (cfg_index == CFG_RING_MINUTES) begin
				ring_min_q <= cfg_data[7:0];
			end
			if (cfg_index == CFG_SNOOZE_MINUTES) begin
				snooze_min_q <= cfg_data[7:0];
			end
			if (cfg_index == CFG_RING_ATTEMPTS) begin
				attempts_cfg_q <= cfg_data[7:0];
			end
		end
	end

	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	asc_match #(
		.N(NREG)
	) u_match (
		.slots  (slot_q),
		.hour   (req_s1.hour),
		.minute (req_s1.minute),
		.second (req_s1.second),
		.result (match)
	);

	// Minutes to seconds: m * 60 = m * 64 - m * 4.
	assign ring_load   = ({6'd0, ring_min_q} << 6) - ({6'd0, ring_min_q} << 2);
	assign snooze_load = ({6'd0, snooze_min_q} << 6) - ({6'd0, snooze_min_q} << 2);
	assign att_dec     = attempts_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			delay_q    <= '0;
			ring_q     <= '0;
			snooze_q   <= '0;
			attempts_q <= '0;
			bright_q   <= '0;
			sound_q    <= '0;
		end else if (adv_s1) begin
			mode_q     <= mode_n;
			delay_q    <= delay_n;
			ring_q     <= ring_n;
			snooze_q   <= snooze_n;
			attempts_q <= attempts_n;
			bright_q   <= bright_n;
			sound_q    <= sound_n;
		end
	end

	always_comb begin
		mode_n     = mode_q;
		mode_p     = mode_q;
		delay_n    = delay_q;
		delay_p    = 1'b0;
		ring_n     = ring_q;
		snooze_n   = snooze_q;
		attempts_n = attempts_q;
		bright_n   = bright_q;
		sound_n    = sound_q;
		start_n    = 1'b0;
		announce_n = 1'b0;
		stop_n     = 1'b0;
		wake_n     = 1'b0;
		hold_led   = 1'b0;
		unique case (func_t'(req_s1.func))
			FUNC_TICK: begin
				if (mode_q == MODE_INIT && delay_q != 2'd0) begin
					delay_n = delay_q - 2'd1;
				end else if (mode_q == MODE_ON && ring_q != '0) begin
					ring_n = ring_q - SEC_W'(1);
				end else if (mode_q == MODE_SNOOZE && snooze_q != '0) begin
					snooze_n = snooze_q - SEC_W'(1);
				end
			end
			FUNC_INIT_DONE: begin
				delay_n = 2'd0;
			end
			FUNC_DISABLE: begin
				if (mode_q == MODE_ON && snooze_min_q != 8'd0) begin
					ring_n = '0;
				end else begin
					mode_n = MODE_DISABLE;
				end
			end
			default: begin
				// A match in off reloads the pre-delay, so init cannot finish in that poll.
				if (match.any_enabled) begin
					if (mode_q == MODE_OFF && match.any_match) begin
						mode_p  = MODE_INIT;
						delay_n = PRE_TICKS;
						delay_p = 1'b1;
					end
				end else if (mode_q != MODE_OFF) begin
					mode_p = MODE_DISABLE;
				end
				mode_n = mode_p;
				unique case (mode_p)
					MODE_INIT: begin
						if (!delay_p && delay_q == 2'd0) begin
							attempts_n = attempts_cfg_q;
							ring_n     = ring_load;
							mode_n     = MODE_ON;
							sound_n    = (req_s1.wanted_sound == 8'd0) ? req_s1.random_value
							                                           : req_s1.wanted_sound - 8'd1;
							announce_n = 1'b1;
						end
					end
					MODE_ON: begin
						if (ring_q != '0) begin
							start_n = !req_s1.player_busy;
							wake_n  = 1'b1;
						end else if (snooze_min_q != 8'd0) begin
							attempts_n = att_dec;
							if (att_dec != 8'd0) begin
								stop_n   = 1'b1;
								snooze_n = snooze_load;
								mode_n   = MODE_SNOOZE;
							end else begin
								mode_n = MODE_DISABLE;
							end
						end else begin
							mode_n = MODE_DISABLE;
						end
					end
					MODE_SNOOZE: begin
						if (snooze_q == '0) begin
							ring_n     = ring_load;
							mode_n     = MODE_ON;
							announce_n = 1'b1;
						end
					end
					MODE_DISABLE: begin
						stop_n = 1'b1;
						mode_n = MODE_WAIT;
					end
					MODE_WAIT: begin
						if (match.any_match) begin
							hold_led = 1'b1;
						end else begin
							mode_n = MODE_OFF;
						end
					end
					default: begin
					end
				endcase
				if (!hold_led) begin
					if (mode_n == MODE_ON || mode_n == MODE_INIT) begin
						bright_n = LED_FULL;
					end else if (bright_q != 10'd0) begin
						bright_n = bright_q - 10'd1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.status        <= mode_n;
			rsp_q.led_level     <= bright_n;
			rsp_q.start_sound   <= start_n;
			rsp_q.sound_number  <= sound_n;
			rsp_q.announce_time <= announce_n;
			rsp_q.stop_sound    <= stop_n;
			rsp_q.wake_display  <= wake_n;
			rsp_q.can_disable   <= (mode_n == MODE_ON || mode_n == MODE_SNOOZE);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A beat that leaves the sequencer carries the mode the sequencer moves into.
	a_status_tracks_mode: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp_q.status == mode_q)
		else $error("result status differs from the mode register");

	a_play_only_on: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.start_sound || rsp_q.wake_display || rsp_q.announce_time)
		|-> rsp_q.status == MODE_ON)
		else $error("play, wake or announce request outside the on mode");

	a_stop_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.stop_sound
		|-> rsp_q.status == MODE_SNOOZE || rsp_q.status == MODE_WAIT)
		else $error("stop request in an unexpected mode");

	a_led_full: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && req_s1.func == FUNC_POLL && (mode_n == MODE_ON || mode_n == MODE_INIT)
		|=> rsp_q.led_level == LED_FULL)
		else $error("LED level not at full while ringing");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp_ready |-> !req_ready)
		else $error("event accepted with both registers full");

endmodule
